/* hdl/dprd_pkg.sv */
// Package for the debug packet receive deframer.
// Holds character codes, phase codes, result kinds and the hex digit decoder.
// No dependencies.
`default_nettype none

package dprd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned NibW   = 4;

  // Framing and handshake characters
  localparam logic [ByteW-1:0] CH_START = 8'h24;  // '$'
  localparam logic [ByteW-1:0] CH_END   = 8'h23;  // '#'
  localparam logic [ByteW-1:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [ByteW-1:0] CH_NAK   = 8'h2D;  // '-'

  // Receive phases
  localparam logic [PhaseW-1:0] PH_HUNT = 2'd0;
  localparam logic [PhaseW-1:0] PH_BODY = 2'd1;
  localparam logic [PhaseW-1:0] PH_CKHI = 2'd2;
  localparam logic [PhaseW-1:0] PH_CKLO = 2'd3;

  // Result kinds
  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [KindW-1:0] KIND_REJECT  = 2'd2;

  typedef struct packed {
    logic            ok;
    logic [NibW-1:0] value;
  } hex_t;

  // Decode one ASCII hex digit, either case. A non-hex character decodes as 0.
  function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = '0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = c[NibW-1:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.value = c[NibW-1:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* hdl/debug_packet_receive_deframer.sv */
// Debug packet receive deframer, top level.
// Depends on dprd_pkg for character codes, phase codes and hex decoding.
//
// Usage:
//   Input channel (in_valid/in_ready/in_rx_byte) takes one received serial
//   character per transaction. Bytes are dropped until '$'; body bytes then
//   come out as payload transactions (out_kind = payload, out_byte = byte,
//   out_is_command set on the first body byte). '#' closes the body, and
//   after two hex checksum characters one verdict transaction follows:
//   accepted with '+' or rejected with '-'. The opening '$' and the closing
//   '#' make no output; a '$' inside the body is an ordinary body byte.
//   Latency: a result is presented on the out_ channel in the cycle after
//   its input transaction is taken. Throughput: one input byte per cycle;
//   the phase and 8-bit checksum update for a byte is combinational logic
//   between the input handshake and the output register.
//   Stall: the output register holds a pending result while out_ready is
//   low; a new input is taken in the same cycle the pending result leaves
//   (in_ready = !out_valid | out_ready), so input stops only while a result
//   is pending and the receiver stalls.
//   Reset (rst_n low, synchronous): back to hunting for '$', checksum state
//   cleared, no result pending.
`default_nettype none

module debug_packet_receive_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [dprd_pkg::ByteW-1:0]  in_rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [dprd_pkg::KindW-1:0]       out_kind,
  output logic [dprd_pkg::ByteW-1:0]       out_byte,
  output logic                             out_is_command
);

  // Receive state
  logic [dprd_pkg::PhaseW-1:0] phase_r,  phase_nxt;
  logic [dprd_pkg::ByteW-1:0]  sum_r,    sum_nxt;
  logic [dprd_pkg::NibW-1:0]   hi_nib_r, hi_nib_nxt;
  logic                        hi_bad_r, hi_bad_nxt;
  logic                        first_r,  first_nxt;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  logic [dprd_pkg::KindW-1:0]  kind_r,      kind_nxt;
  logic [dprd_pkg::ByteW-1:0]  byte_r,      byte_nxt;
  logic                        cmd_r,       cmd_nxt;

  logic                        in_fire;
  logic                        res_emit;
  dprd_pkg::hex_t              hex;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign hex      = dprd_pkg::hex_decode(in_rx_byte);

  // Per-byte phase step; res_emit marks a byte that produces a result.
  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    hi_nib_nxt = hi_nib_r;
    hi_bad_nxt = hi_bad_r;
    first_nxt  = first_r;
    res_emit   = 1'b0;
    kind_nxt   = kind_r;
    byte_nxt   = byte_r;
    cmd_nxt    = cmd_r;
    if (in_fire) begin
      case (phase_r)
        dprd_pkg::PH_HUNT: begin
          if (in_rx_byte == dprd_pkg::CH_START) begin
            sum_nxt   = '0;
            first_nxt = 1'b1;
            phase_nxt = dprd_pkg::PH_BODY;
          end
        end
        dprd_pkg::PH_BODY: begin
          first_nxt = 1'b0;
          if (in_rx_byte == dprd_pkg::CH_END) begin
            phase_nxt = dprd_pkg::PH_CKHI;
          end else begin
            res_emit = 1'b1;
            kind_nxt = dprd_pkg::KIND_PAYLOAD;
            byte_nxt = in_rx_byte;
            cmd_nxt  = first_r;
            sum_nxt  = sum_r + in_rx_byte;
          end
        end
        dprd_pkg::PH_CKHI: begin
          hi_nib_nxt = hex.value;
          hi_bad_nxt = !hex.ok;
          phase_nxt  = dprd_pkg::PH_CKLO;
        end
        dprd_pkg::PH_CKLO: begin
          res_emit  = 1'b1;
          cmd_nxt   = 1'b0;
          phase_nxt = dprd_pkg::PH_HUNT;
          if (hex.ok && !hi_bad_r && ({hi_nib_r, hex.value} == sum_r)) begin
            kind_nxt = dprd_pkg::KIND_ACCEPT;
            byte_nxt = dprd_pkg::CH_ACK;
          end else begin
            kind_nxt = dprd_pkg::KIND_REJECT;
            byte_nxt = dprd_pkg::CH_NAK;
          end
        end
        default: begin
          phase_nxt = dprd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // A result is pending after a new one is loaded, or while the old one waits.
  assign out_valid_nxt = res_emit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dprd_pkg::PH_HUNT;
      sum_r       <= '0;
      hi_nib_r    <= '0;
      hi_bad_r    <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
      hi_nib_r    <= hi_nib_nxt;
      hi_bad_r    <= hi_bad_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: loaded only when a result is produced, no reset needed.
  always_ff @(posedge clk) begin
    if (res_emit) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      cmd_r  <= cmd_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_byte       = byte_r;
  assign out_is_command = cmd_r;

  // Checks
  a_verdict_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != dprd_pkg::KIND_PAYLOAD) |-> !out_is_command)
    else $error("verdict flagged as command letter");

  a_verdict_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == dprd_pkg::KIND_ACCEPT) |-> out_byte == dprd_pkg::CH_ACK)
    else $error("accept verdict without ack character");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == dprd_pkg::PH_HUNT && in_rx_byte == dprd_pkg::CH_START)
    |=> (first_r && sum_r == '0 && phase_r == dprd_pkg::PH_BODY))
    else $error("start character did not open a packet");

  a_cklo_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == dprd_pkg::PH_CKLO)
    |=> (out_valid && phase_r == dprd_pkg::PH_HUNT && out_kind != dprd_pkg::KIND_PAYLOAD))
    else $error("second checksum digit gave no verdict");

  a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == dprd_pkg::PH_HUNT) |-> !res_emit)
    else $error("result while hunting");

endmodule

`default_nettype wire

/* test/tb_debug_packet_receive_deframer.sv */
// Testbench for debug_packet_receive_deframer: framed, broken and noisy byte streams with
// random idling on both channels, checked against an in-bench prediction of every result.
// Depends on dprd_pkg and the deframer RTL.
`default_nettype none

module tb_debug_packet_receive_deframer;
  import dprd_pkg::*;

  localparam int ClkHalf       = 6;      // 12 unit period
  localparam int HoldCycles    = 300;    // long receiver hold-off
  localparam int FullRateItems = 200;    // framed bytes with no idling at all
  localparam int RandItems     = 900;    // framed bytes with random idling
  localparam int DrainLimit    = 2000;
  localparam int TimeoutUnits  = 2_400_000;

  // How the two checksum characters of a frame are built
  typedef enum int {
    CK_GOOD,     // matches the body sum
    CK_WRONG,    // valid hex, wrong value
    CK_BAD_HI,   // high character is not hex
    CK_BAD_LO,   // low character is not hex
    CK_GARBAGE   // two arbitrary bytes
  } ck_mode_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data;
    logic             cmd;
  } rx_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] in_rx_byte = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [KindW-1:0] out_kind;
  logic [ByteW-1:0] out_byte;
  logic             out_is_command;

  debug_packet_receive_deframer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_is_command (out_is_command)
  );

  always #ClkHalf clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shared run state
  // ---------------------------------------------------------------------------
  int  in_idle_pct  = 38;   // chance in 100 that the sender skips a cycle
  int  out_idle_pct = 38;   // chance in 100 that the receiver drops out_ready
  bit  hold_go      = 1'b0; // test asks the receiver for one long hold-off
  int  err_cnt      = 0;

  int  bytes_sent   = 0;
  int  frame_bytes  = 0;    // bytes sent as part of frames, noise excluded
  int  frames_sent  = 0;
  int  n_payload    = 0;
  int  n_command    = 0;
  int  n_accept     = 0;
  int  n_reject     = 0;

  logic [ByteW-1:0] body_q[$];    // body of the next frame to send
  rx_result_t       predicted_q[$];

  // ---------------------------------------------------------------------------
  // Deframer prediction: own copy of the receive state
  // ---------------------------------------------------------------------------
  logic [PhaseW-1:0] rx_phase   = PH_HUNT;
  logic [ByteW-1:0]  rx_sum     = '0;
  logic [NibW-1:0]   rx_hi_nib  = '0;
  logic              rx_hi_bad  = 1'b0;
  logic              rx_first   = 1'b0;

  // ASCII hex digit to value; returns 0 with value 0 for anything else
  function automatic bit hex_digit(input logic [ByteW-1:0] c, output logic [NibW-1:0] v);
    bit ok;
    ok = 1'b1;
    v  = '0;
    if (c >= 8'h30 && c <= 8'h39) begin        // '0'..'9'
      v = NibW'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin // 'A'..'F'
      v = NibW'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin // 'a'..'f'
      v = NibW'(c - 8'h61 + 8'd10);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  // Advance the predicted state by one accepted byte, queueing any result
  function automatic void deframe_predict(input logic [ByteW-1:0] c);
    logic [NibW-1:0] v;
    bit              ok;
    rx_result_t      r;
    case (rx_phase)
      PH_HUNT: begin
        if (c == CH_START) begin
          rx_sum   = '0;
          rx_first = 1'b1;
          rx_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (c == CH_END) begin
          rx_first = 1'b0;
          rx_phase = PH_CKHI;
        end else begin
          r.kind = KIND_PAYLOAD;
          r.data = c;
          r.cmd  = rx_first;
          predicted_q.push_back(r);
          rx_first = 1'b0;
          rx_sum   = rx_sum + c;
        end
      end
      PH_CKHI: begin
        ok        = hex_digit(c, v);
        rx_hi_nib = v;
        rx_hi_bad = !ok;
        rx_phase  = PH_CKLO;
      end
      default: begin
        ok = hex_digit(c, v);
        if (ok && !rx_hi_bad && {rx_hi_nib, v} == rx_sum) begin
          r = '{kind: KIND_ACCEPT, data: CH_ACK, cmd: 1'b0};
        end else begin
          r = '{kind: KIND_REJECT, data: CH_NAK, cmd: 1'b0};
        end
        predicted_q.push_back(r);
        rx_phase = PH_HUNT;
      end
    endcase
  endfunction

  // Compare one output transaction with the oldest prediction
  function automatic void check_result();
    rx_result_t e;
    if (predicted_q.size() == 0) begin
      $error("unexpected result transaction: kind %0d byte %02h", out_kind, out_byte);
      err_cnt++;
      return;
    end
    e = predicted_q.pop_front();
    if (out_kind !== e.kind) begin
      $error("out_kind: expected %0d, actual %0d", e.kind, out_kind);
      err_cnt++;
    end
    if (out_byte !== e.data) begin
      $error("out_byte: expected %02h, actual %02h", e.data, out_byte);
      err_cnt++;
    end
    if (out_is_command !== e.cmd) begin
      $error("out_is_command: expected %0b, actual %0b", e.cmd, out_is_command);
      err_cnt++;
    end
    case (e.kind)
      KIND_PAYLOAD: begin
        n_payload++;
        if (e.cmd) n_command++;
      end
      KIND_ACCEPT: n_accept++;
      default:     n_reject++;
    endcase
  endfunction

  // Both channels are sampled at the rising edge. The output check runs first:
  // a result leaving now always belongs to an input taken at an earlier edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) deframe_predict(in_rx_byte);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random out_ready, plus one long hold-off counted here
  // ---------------------------------------------------------------------------
  int hold_left  = 0;
  bit hold_taken = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one byte, with random idle cycles first, and wait for the transaction.
  task automatic send_byte(input logic [ByteW-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  function automatic logic [ByteW-1:0] hex_char(input logic [NibW-1:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + ByteW'(n);
    return (lower ? 8'h61 : 8'h41) + ByteW'(n) - 8'd10;
  endfunction

  function automatic logic [ByteW-1:0] non_hex_char();
    logic [ByteW-1:0] c;
    logic [NibW-1:0]  v;
    do c = ByteW'($urandom_range(255)); while (hex_digit(c, v));
    return c;
  endfunction

  // Send '$', body_q, '#' and two checksum characters built as mode says
  task automatic send_frame(input ck_mode_e mode, input bit lower);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] ck;
    logic [ByteW-1:0] hi_c;
    logic [ByteW-1:0] lo_c;
    sum = '0;
    send_byte(CH_START);
    foreach (body_q[i]) begin
      send_byte(body_q[i]);
      sum = sum + body_q[i];
    end
    send_byte(CH_END);
    ck   = (mode == CK_WRONG) ? (sum ^ ByteW'($urandom_range(255, 1))) : sum;
    hi_c = hex_char(ck[7:4], lower);
    lo_c = hex_char(ck[3:0], lower);
    case (mode)
      CK_BAD_HI:  hi_c = non_hex_char();
      CK_BAD_LO:  lo_c = non_hex_char();
      CK_GARBAGE: begin
        hi_c = ByteW'($urandom_range(255));
        lo_c = ByteW'($urandom_range(255));
      end
      default: ;
    endcase
    send_byte(hi_c);
    send_byte(lo_c);
    frames_sent++;
    frame_bytes += body_q.size() + 4;
  endtask

  // Random body; '#' would close it early, so it becomes an embedded '$'
  function automatic void fill_body(input int len);
    logic [ByteW-1:0] c;
    body_q.delete();
    repeat (len) begin
      c = ByteW'($urandom_range(255));
      if (c == CH_END || $urandom_range(19) == 0) c = CH_START;
      body_q.push_back(c);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Bytes before any '$' are dropped, including the end and ack characters
  task automatic test_hunting();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_END);
    send_byte(CH_ACK);
  endtask

  // "$#00": verdict only, accepted
  task automatic test_empty_frame();
    body_q.delete();
    send_frame(CK_GOOD, 1'b0);
  endtask

  // Body with zero, all ones, an embedded '$' and a byte giving a lower case digit
  task automatic test_body_extremes();
    body_q = '{8'h00, 8'hFF, CH_START, 8'h7A};
    send_frame(CK_GOOD, 1'b1);
  endtask

  // Wrong value, non-hex high digit on an empty body, non-hex low digit
  task automatic test_bad_checksums();
    body_q = '{8'h67};
    send_frame(CK_WRONG, 1'b0);
    body_q.delete();
    send_frame(CK_BAD_HI, 1'b0);
    body_q = '{8'h80};
    send_frame(CK_BAD_LO, 1'b1);
  endtask

  // Receiver holds off for a long stretch while a long frame keeps coming,
  // so the output register fills and in_ready drops
  task automatic test_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_go      = 1'b1;
    fill_body(40);
    send_frame(CK_GOOD, 1'($urandom_range(1)));
  endtask

  // Mostly well-formed frames with random content; the rest is line noise
  // and frames cut off by garbage checksum characters
  task automatic run_traffic(input int n_items);
    int       start;
    int       pick;
    int       len;
    ck_mode_e mode;
    start = frame_bytes;
    while (frame_bytes - start < n_items) begin
      pick = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8);
      if (pick < 75) begin
        pick = $urandom_range(99);
        if (pick < 70)      mode = CK_GOOD;
        else if (pick < 85) mode = CK_WRONG;
        else if (pick < 92) mode = CK_BAD_HI;
        else                mode = CK_BAD_LO;
        fill_body(len);
        send_frame(mode, 1'($urandom_range(1)));
      end else if (pick < 88) begin
        repeat ($urandom_range(4, 1)) send_byte(ByteW'($urandom_range(255)));
      end else begin
        fill_body(len);
        send_frame(CK_GARBAGE, 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_full_rate();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_traffic(FullRateItems);
  endtask

  task automatic test_random_idling();
    in_idle_pct  = 38;
    out_idle_pct = 38;
    run_traffic(RandItems);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int drain;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_hunting();
    test_empty_frame();
    test_body_extremes();
    test_bad_checksums();
    test_backpressure();
    test_full_rate();
    test_random_idling();

    @(negedge clk);
    in_valid <= 1'b0;

    // Results are registered behind their input; wait out the receiver
    drain = 0;
    while (predicted_q.size() != 0 && drain < DrainLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (predicted_q.size() != 0) begin
      $error("%0d expected result transactions never arrived", predicted_q.size());
      err_cnt++;
    end

    $display("Run: %0d bytes offered and taken, %0d frames built (noise excluded).",
             bytes_sent, frames_sent);
    $display("Seen: %0d payload bytes (%0d command letters), %0d acks, %0d naks.",
             n_payload, n_command, n_accept, n_reject);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutUnits);
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
